// File: rtl/pfbc_pkg.sv
// shared types, constants and defaults of the page flush byte counter
package pfbc_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 4 << 10;
  localparam int unsigned NUM_PAGES_DEF  = 1024;

  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned SIZE_W       = 8;
  localparam int unsigned LEN_W        = 23;
  localparam int unsigned OFFSET_W     = 48;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned CNT_W        = 17;
  localparam int unsigned FILE_PAGE_W  = 37;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd194;
  localparam logic [CNT_W-1:0] CNT_MAX         = 17'd65790;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE      = 2'd0,
    CFG_POOL_LENGTH    = 2'd1,
    CFG_FILE_OFFSET    = 2'd2,
    CFG_SYNC_THRESHOLD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   pool_base;
    logic [LEN_W-1:0]    pool_length;
    logic [OFFSET_W-1:0] file_offset;
    logic [THR_W-1:0]    sync_threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } state_e;

endpackage

// File: rtl/pfbc_if.sv
// valid/ready channels for flush events and page reports
interface pfbc_in_if
  import pfbc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] flush_address;
  logic [SIZE_W-1:0] access_size;

  modport source (output valid, output flush_address, output access_size, input ready);
  modport sink   (input valid, input flush_address, input access_size, output ready);
endinterface

interface pfbc_out_if
  import pfbc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [FILE_PAGE_W-1:0] file_page;
  logic [CNT_W-1:0]       flushed_bytes;

  modport source (output valid, output file_page, output flushed_bytes, input ready);
  modport sink   (input valid, input file_page, input flushed_bytes, output ready);
endinterface

// File: rtl/pfbc_cfg_regs.sv
// configuration register file, write only
module pfbc_cfg_regs
  import pfbc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POOL_BASE:      cfg_d.pool_base      = cfg_data_i;
        CFG_POOL_LENGTH:    cfg_d.pool_length    = cfg_data_i[LEN_W-1:0];
        CFG_FILE_OFFSET:    cfg_d.file_offset    = cfg_data_i[OFFSET_W-1:0];
        CFG_SYNC_THRESHOLD: cfg_d.sync_threshold = cfg_data_i[THR_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base      <= '0;
      cfg_q.pool_length    <= '0;
      cfg_q.file_offset    <= '0;
      cfg_q.sync_threshold <= THRESHOLD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/pfbc_counter_ram.sv
// single port write, single port read counter memory, registered read
module pfbc_counter_ram
  import pfbc_pkg::*;
#(
  parameter int unsigned DEPTH = NUM_PAGES_DEF,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [CNT_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/page_flush_byte_counter.sv
// Page flush byte counter: each accepted flush beat whose address falls in
// [pool_base, pool_base + pool_length) adds its access size to the counter of
// page (address - pool_base) / PAGE_BYTES, held in a NUM_PAGES-entry memory;
// pages at or beyond NUM_PAGES are ignored. When the updated count reaches
// sync_threshold the counter is cleared and a report beat carries the file
// page (page + file_offset / PAGE_BYTES, modulo 2^37) and the count. One flush
// is in work at a time: a counted flush passes through accept, address check
// and memory read, add/compare and write back, and a flush outside the region
// ends after the address check; the input is ready again once the flush is
// done. The registered memory read feeds the add/compare step. A finished
// report sits in an output register, so new flushes are taken while it waits;
// only a second report with the first still untaken holds the update step.
// After reset the block clears the counter memory one entry per cycle, with
// the input not ready; configuration writes are taken throughout and do not
// clear the counters.
module page_flush_byte_counter
  import pfbc_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned NUM_PAGES  = NUM_PAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pfbc_in_if.sink               flush_i,
  pfbc_out_if.source            report_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned AW         = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  cfg_t cfg;

  // control state
  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;

  // item in work
  logic [ADDR_W-1:0]      addr_q;
  logic [SIZE_W-1:0]      size_q;
  logic [AW-1:0]          page_q;
  logic [FILE_PAGE_W-1:0] fpage_q;

  // report register payload
  logic [FILE_PAGE_W-1:0] out_page_q;
  logic [CNT_W-1:0]       out_cnt_q;

  // memory ports
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] mem_wdata, mem_rdata;

  // datapath
  logic              in_ready;
  logic              accept;
  logic [ADDR_W-1:0] delta;
  logic [ADDR_W-1:0] page_full;
  logic              hit;
  logic [AW-1:0]     page_idx;
  logic [CNT_W:0]    sum_wide;
  logic [CNT_W-1:0]  cnt;
  logic              report;
  logic              slot_free;
  logic              upd_done;
  logic              clr_done;

  pfbc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfbc_counter_ram #(
    .DEPTH (NUM_PAGES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (page_idx),
    .rdata_o (mem_rdata)
  );

  assign accept = flush_i.valid && in_ready;

  // region check: wrapped difference must fall below the length and map
  // to a page that the memory holds
  assign delta     = addr_q - cfg.pool_base;
  assign page_full = delta >> PAGE_SHIFT;
  assign page_idx  = page_full[AW-1:0];
  assign hit       = (addr_q >= cfg.pool_base)
                  && (delta < ADDR_W'(cfg.pool_length))
                  && (page_full < ADDR_W'(NUM_PAGES));

  // counter update on the read data
  assign sum_wide  = {1'b0, mem_rdata} + (CNT_W + 1)'(size_q);
  assign cnt       = sum_wide[CNT_W-1:0];
  assign report    = cnt >= CNT_W'(cfg.sync_threshold);
  assign slot_free = !out_valid_q || report_o.ready;
  assign upd_done  = !report || slot_free;
  assign clr_done  = clr_q == AW'(NUM_PAGES - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_LOOK;
      ST_LOOK:   state_d = hit ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: if (upd_done) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = page_q;
    mem_wdata = '0;
    clr_d     = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE:   in_ready = 1'b1;
      ST_LOOK:   mem_re = hit;
      ST_UPDATE: begin
        // a reported page restarts from zero
        mem_we    = upd_done;
        mem_wdata = report ? '0 : cnt;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // report register: cleared by a taken beat, loaded by a reporting update
  always_comb begin
    out_valid_d = out_valid_q;
    if (report_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_UPDATE && report && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= flush_i.flush_address;
      size_q <= flush_i.access_size;
    end
    if (state_q == ST_LOOK) begin
      page_q  <= page_idx;
      // low bits of an unaligned offset drop out with the shift
      fpage_q <= FILE_PAGE_W'(cfg.file_offset >> PAGE_SHIFT) + FILE_PAGE_W'(page_idx);
    end
    if (state_q == ST_UPDATE && report && slot_free) begin
      out_page_q <= fpage_q;
      out_cnt_q  <= cnt;
    end
  end

  assign flush_i.ready          = in_ready;
  assign report_o.valid         = out_valid_q;
  assign report_o.file_page     = out_page_q;
  assign report_o.flushed_bytes = out_cnt_q;

endmodule

// File: rtl/pfbc_checker.sv
// port level checks of the page flush byte counter, bound to the top level
module pfbc_checker
  import pfbc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   flush_valid_i,
  input logic                   flush_ready_i,
  input logic                   report_valid_i,
  input logic                   report_ready_i,
  input logic [FILE_PAGE_W-1:0] file_page_i,
  input logic [CNT_W-1:0]       flushed_bytes_i
);

  // stalled report beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_valid_i && !report_ready_i |=>
      report_valid_i && $stable(file_page_i) && $stable(flushed_bytes_i))
    else $error("report payload changed while stalled");

  // counter memory clearing holds the input off right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !flush_ready_i)
    else $error("flush taken during counter clearing");

  // one flush in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_valid_i && flush_ready_i |=> !flush_ready_i)
    else $error("second flush taken while one is in work");

  // a reported count never exceeds CNT_MAX, the largest threshold plus the largest access size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_valid_i |-> flushed_bytes_i <= CNT_MAX)
    else $error("reported count out of range");

endmodule

bind page_flush_byte_counter pfbc_checker u_pfbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .flush_valid_i   (flush_i.valid),
  .flush_ready_i   (flush_i.ready),
  .report_valid_i  (report_o.valid),
  .report_ready_i  (report_o.ready),
  .file_page_i     (report_o.file_page),
  .flushed_bytes_i (report_o.flushed_bytes)
);
